### design/dnsat_pkg.sv
// Shared types and constants for the DNS answer minimum-TTL parser.
// No dependencies; imported by every module of the block.
`default_nettype none
package dnsat_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned TTL_W  = 31;
    localparam int unsigned CNT_W  = 16;
    localparam int unsigned IDX_W  = 4;

    // Header byte positions
    localparam logic [IDX_W-1:0] HDR_QD_HI = 4'd4;
    localparam logic [IDX_W-1:0] HDR_QD_LO = 4'd5;
    localparam logic [IDX_W-1:0] HDR_AN_HI = 4'd6;
    localparam logic [IDX_W-1:0] HDR_AN_LO = 4'd7;
    localparam logic [IDX_W-1:0] HDR_LAST  = 4'd11;

    // QTYPE/QCLASS block: four bytes
    localparam logic [IDX_W-1:0] QFIX_LAST = 4'd3;

    // Answer fixed block: TYPE, CLASS, TTL, RDLENGTH
    localparam logic [IDX_W-1:0] AFIX_TTL_3 = 4'd4;
    localparam logic [IDX_W-1:0] AFIX_TTL_2 = 4'd5;
    localparam logic [IDX_W-1:0] AFIX_TTL_1 = 4'd6;
    localparam logic [IDX_W-1:0] AFIX_TTL_0 = 4'd7;
    localparam logic [IDX_W-1:0] AFIX_RDL_1 = 4'd8;
    localparam logic [IDX_W-1:0] AFIX_RDL_0 = 4'd9;

    // Label type in the top two bits of a length byte
    localparam logic [1:0] LBL_NORMAL = 2'b00;
    localparam logic [1:0] LBL_PTR    = 2'b11;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_NAME   = 3'd1,
        PH_PTR    = 3'd2,
        PH_QFIX   = 3'd3,
        PH_AFIX   = 3'd4,
        PH_RDATA  = 3'd5,
        PH_DONE   = 3'd6,
        PH_FAIL   = 3'd7
    } t_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
    } t_in_item;

    typedef struct packed {
        logic             ttl_valid;
        logic [TTL_W-1:0] min_ttl;
    } t_result;

endpackage
`default_nettype wire

### design/dnsat_in_reg.sv
// Input register stage for the DNS minimum-TTL parser.
// Depends on dnsat_pkg.
`default_nettype none
module dnsat_in_reg
    import dnsat_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire t_in_item          i_item,
    input  wire logic              i_advance,
    output logic                   o_valid,
    output t_in_item               o_item
);

    logic     r_valid;
    t_in_item r_item;

    // Refill when empty or whenever the held item moves on in the same cycle
    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule
`default_nettype wire

### design/dnsat_parse.sv
// Per-byte DNS message walker: header, questions, answers, TTL minimum.
// Depends on dnsat_pkg.
`default_nettype none
module dnsat_parse
    import dnsat_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_step,
    input  wire t_in_item i_item,
    output t_result       o_res
);

    t_phase            r_phase,          n_phase;
    logic [IDX_W-1:0]  r_header_count,   n_header_count;
    logic [CNT_W-1:0]  r_questions_left, n_questions_left;
    logic [CNT_W-1:0]  r_answers_left,   n_answers_left;
    logic [CNT_W-1:0]  r_skip_left,      n_skip_left;
    logic [IDX_W-1:0]  r_field_count,    n_field_count;
    logic [TTL_W-1:0]  r_ttl_gather,     n_ttl_gather;
    logic [TTL_W-1:0]  r_lowest_ttl,     n_lowest_ttl;
    logic              r_lowest_seen,    n_lowest_seen;

    logic [BYTE_W-1:0] b;
    logic [CNT_W-1:0]  skip_dec;
    logic              done_ok;

    assign b        = i_item.data_byte;
    assign skip_dec = r_skip_left - CNT_W'(1);

    always_comb begin
        n_phase          = r_phase;
        n_header_count   = r_header_count;
        n_questions_left = r_questions_left;
        n_answers_left   = r_answers_left;
        n_skip_left      = r_skip_left;
        n_field_count    = r_field_count;
        n_ttl_gather     = r_ttl_gather;
        n_lowest_ttl     = r_lowest_ttl;
        n_lowest_seen    = r_lowest_seen;

        case (r_phase)
            PH_HEADER: begin
                case (r_header_count)
                    HDR_QD_HI: n_questions_left = {b, 8'h00};
                    HDR_QD_LO: n_questions_left = {r_questions_left[CNT_W-1:BYTE_W], b};
                    HDR_AN_HI: n_answers_left   = {b, 8'h00};
                    HDR_AN_LO: n_answers_left   = {r_answers_left[CNT_W-1:BYTE_W], b};
                    default: ;
                endcase
                if (r_header_count == HDR_LAST) begin
                    n_phase     = (r_answers_left == '0) ? PH_FAIL : PH_NAME;
                    n_skip_left = '0;
                end
                n_header_count = r_header_count + IDX_W'(1);
            end
            PH_NAME: begin
                if (r_skip_left != '0) begin
                    n_skip_left = skip_dec;
                end else if (b[7:6] == LBL_PTR) begin
                    n_phase = PH_PTR;
                end else if (b == '0) begin
                    n_field_count = '0;
                    n_phase = (r_questions_left != '0) ? PH_QFIX : PH_AFIX;
                end else if (b[7:6] != LBL_NORMAL) begin
                    n_phase = PH_FAIL;
                end else begin
                    n_skip_left = {8'h00, b};
                end
            end
            PH_PTR: begin
                // Second pointer byte ends the name; the target is not followed
                n_field_count = '0;
                n_phase = (r_questions_left != '0) ? PH_QFIX : PH_AFIX;
            end
            PH_QFIX: begin
                if (r_field_count == QFIX_LAST) begin
                    n_questions_left = r_questions_left - CNT_W'(1);
                    n_skip_left      = '0;
                    n_phase          = PH_NAME;
                end
                n_field_count = r_field_count + IDX_W'(1);
            end
            PH_AFIX: begin
                case (r_field_count)
                    AFIX_TTL_3: n_ttl_gather = {b[6:0], 24'h000000};
                    AFIX_TTL_2: n_ttl_gather[23:16] = b;
                    AFIX_TTL_1: n_ttl_gather[15:8]  = b;
                    AFIX_TTL_0: n_ttl_gather[7:0]   = b;
                    AFIX_RDL_1: n_skip_left = {b, 8'h00};
                    AFIX_RDL_0: begin
                        n_skip_left = {r_skip_left[CNT_W-1:BYTE_W], b};
                        if (!r_lowest_seen || (r_ttl_gather < r_lowest_ttl)) begin
                            n_lowest_ttl  = r_ttl_gather;
                            n_lowest_seen = 1'b1;
                        end
                        n_answers_left = r_answers_left - CNT_W'(1);
                        if ({r_skip_left[CNT_W-1:BYTE_W], b} == '0) begin
                            n_phase = (n_answers_left == '0) ? PH_DONE : PH_NAME;
                        end else begin
                            n_phase = PH_RDATA;
                        end
                    end
                    default: ;
                endcase
                n_field_count = r_field_count + IDX_W'(1);
            end
            PH_RDATA: begin
                n_skip_left = skip_dec;
                if (skip_dec == '0) begin
                    n_phase = (r_answers_left == '0) ? PH_DONE : PH_NAME;
                end
            end
            default: ;
        endcase
    end

    // Result seen on the final byte, taken from the updated state
    assign done_ok         = (n_phase == PH_DONE) && n_lowest_seen;
    assign o_res.ttl_valid = done_ok;
    assign o_res.min_ttl   = done_ok ? n_lowest_ttl : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_item.last_byte)) begin
            r_phase          <= PH_HEADER;
            r_header_count   <= '0;
            r_questions_left <= '0;
            r_answers_left   <= '0;
            r_skip_left      <= '0;
            r_field_count    <= '0;
            r_ttl_gather     <= '0;
            r_lowest_ttl     <= '0;
            r_lowest_seen    <= 1'b0;
        end else if (i_step) begin
            r_phase          <= n_phase;
            r_header_count   <= n_header_count;
            r_questions_left <= n_questions_left;
            r_answers_left   <= n_answers_left;
            r_skip_left      <= n_skip_left;
            r_field_count    <= n_field_count;
            r_ttl_gather     <= n_ttl_gather;
            r_lowest_ttl     <= n_lowest_ttl;
            r_lowest_seen    <= n_lowest_seen;
        end
    end

`ifndef SYNTHESIS
    a_rdata_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_RDATA) |-> (r_skip_left != '0))
        else $error("RDATA phase with nothing left to skip");

    a_header_no_ttl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HEADER) |-> !r_lowest_seen)
        else $error("TTL minimum recorded while still in the header");

    a_restart_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_item.last_byte) |=>
            ((r_phase == PH_HEADER) && (r_header_count == '0)))
        else $error("parser did not restart after the final byte");
`endif

endmodule
`default_nettype wire

### design/dnsat_out_reg.sv
// Result register driving the output stream of the minimum-TTL parser.
// Depends on dnsat_pkg.
`default_nettype none
module dnsat_out_reg
    import dnsat_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_result i_res,
    output logic         o_free,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_result      o_res
);

    logic    r_valid;
    t_result r_res;

    // Slot can take a new result if empty or emptied this cycle
    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule
`default_nettype wire

### design/dns_answer_min_ttl_parser.sv
// DNS answer minimum-TTL parser, top level.
// Result path: an accepted final byte lands in the input register, and the
// parse step loads the result register from it once the result slot is free.
// Throughput: one message byte per cycle; the only stall is a final byte
// waiting while the previous result is still held on the output.
// Reset: synchronous, active low; clears both handshake stages and the parser.
`default_nettype none
module dns_answer_min_ttl_parser
    import dnsat_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Byte stream in
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  wire logic        i_s_axis_tlast,   // last_byte
    // Result stream out
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [31:0]      o_m_axis_tdata,   // [30:0] min_ttl, [31] zero pad
    output logic             o_m_axis_tuser    // ttl_valid
);

    t_in_item in_item;
    t_in_item held_item;
    logic     held_valid;
    logic     out_free;
    logic     advance;
    t_result  step_res;
    t_result  out_res;

    assign in_item.data_byte = i_s_axis_tdata;
    assign in_item.last_byte = i_s_axis_tlast;

    // Advance the held byte unless it is a final byte and the result slot is full
    assign advance = held_valid && (!held_item.last_byte || out_free);

    dnsat_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_item    (in_item),
        .i_advance (advance),
        .o_valid   (held_valid),
        .o_item    (held_item)
    );

    // Walk the message state one byte per step
    dnsat_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_item  (held_item),
        .o_res   (step_res)
    );

    // Load a result only on the final byte of a message
    dnsat_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (advance && held_item.last_byte),
        .i_res   (step_res),
        .o_free  (out_free),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_res   (out_res)
    );

    assign o_m_axis_tdata = {1'b0, out_res.min_ttl};
    assign o_m_axis_tuser = out_res.ttl_valid;

`ifndef SYNTHESIS
    a_invalid_zero_ttl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser) |-> (o_m_axis_tdata == '0))
        else $error("invalid result carries a nonzero TTL");

    a_pad_bit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !o_m_axis_tdata[31])
        else $error("TTL sign bit set on output");

    a_final_byte_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (held_valid && held_item.last_byte && o_m_axis_tvalid && !i_m_axis_tready)
            |=> held_valid)
        else $error("final byte dropped while result slot was full");
`endif

endmodule
`default_nettype wire

### test/tb_dns_answer_min_ttl_parser.sv
// Self-checking testbench for dns_answer_min_ttl_parser: streams DNS responses
// byte by byte and checks each per-message minimum-TTL result against a predictor.
// Depends on dnsat_pkg (design/dnsat_pkg.sv) and the parser top level.
`default_nettype none
module tb_dns_answer_min_ttl_parser
    import dnsat_pkg::*;
;

    localparam int IDLE_LIMIT  = 2000;  // cycles without any handshake before giving up
    localparam int BYTE_TARGET = 2000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    t_in_item    in_item = '0;
    logic        rx_ready = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [31:0] o_m_axis_tdata;
    logic        o_m_axis_tuser;

    dns_answer_min_ttl_parser dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (in_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (in_item.data_byte),  // [7:0] data_byte
        .i_s_axis_tlast  (in_item.last_byte),  // last_byte
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (rx_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),     // [30:0] min_ttl, [31] zero pad
        .o_m_axis_tuser  (o_m_axis_tuser)      // ttl_valid
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor: a private copy of the parser state, advanced once per
    // accepted byte. The result of a message is queued on its final byte.
    // ------------------------------------------------------------------
    t_phase           stage;
    logic [IDX_W-1:0] hdr_pos;
    logic [CNT_W-1:0] questions_todo;
    logic [CNT_W-1:0] answers_todo;
    logic [CNT_W-1:0] bytes_to_skip;
    logic [IDX_W-1:0] fix_pos;
    logic [TTL_W-1:0] ttl_build;
    logic [TTL_W-1:0] ttl_low;
    logic             ttl_any;

    t_in_item byte_backlog[$];  // bytes waiting to be driven
    t_result  min_ttl_due[$];   // results predicted but not yet seen
    logic [7:0] msg_bytes[$];   // message under construction

    int errors;
    int bytes_taken;
    int msgs_queued;
    int results_seen;
    int valid_seen;

    task automatic parser_clear();
        stage          = PH_HEADER;
        hdr_pos        = '0;
        questions_todo = '0;
        answers_todo   = '0;
        bytes_to_skip  = '0;
        fix_pos        = '0;
        ttl_build      = '0;
        ttl_low        = '0;
        ttl_any        = 1'b0;
    endtask

    // A name is over: questions still owed take QTYPE/QCLASS next, else answer fields.
    task automatic name_over();
        fix_pos = '0;
        stage   = (questions_todo != 0) ? PH_QFIX : PH_AFIX;
    endtask

    task automatic answer_over();
        stage = (answers_todo == 0) ? PH_DONE : PH_NAME;
    endtask

    task automatic parse_dns_byte(input t_in_item it);
        logic [7:0] b;
        logic       ok;
        b = it.data_byte;
        case (stage)
            PH_HEADER: begin
                case (hdr_pos)
                    HDR_QD_HI: questions_todo = {b, 8'h00};
                    HDR_QD_LO: questions_todo = questions_todo | {8'h00, b};
                    HDR_AN_HI: answers_todo   = {b, 8'h00};
                    HDR_AN_LO: answers_todo   = answers_todo | {8'h00, b};
                    default: ;
                endcase
                if (hdr_pos == HDR_LAST) begin
                    stage         = (answers_todo == 0) ? PH_FAIL : PH_NAME;
                    bytes_to_skip = '0;
                end
                hdr_pos = hdr_pos + IDX_W'(1);
            end
            PH_NAME: begin
                if (bytes_to_skip != 0) begin
                    bytes_to_skip = bytes_to_skip - CNT_W'(1);
                end else if (b[7:6] == LBL_PTR) begin
                    stage = PH_PTR;
                end else if (b == 8'h00) begin
                    name_over();
                end else if (b[7:6] != LBL_NORMAL) begin
                    stage = PH_FAIL;
                end else begin
                    bytes_to_skip = {8'h00, b};
                end
            end
            // second pointer byte: step over, never follow
            PH_PTR: name_over();
            PH_QFIX: begin
                if (fix_pos == QFIX_LAST) begin
                    questions_todo = questions_todo - CNT_W'(1);
                    bytes_to_skip  = '0;
                    stage          = PH_NAME;
                end
                fix_pos = fix_pos + IDX_W'(1);
            end
            PH_AFIX: begin
                case (fix_pos)
                    AFIX_TTL_3: ttl_build = {b[6:0], 24'h000000};
                    AFIX_TTL_2: ttl_build = ttl_build | {7'h00, b, 16'h0000};
                    AFIX_TTL_1: ttl_build = ttl_build | {15'h0000, b, 8'h00};
                    AFIX_TTL_0: ttl_build = ttl_build | {23'h000000, b};
                    AFIX_RDL_1: bytes_to_skip = {b, 8'h00};
                    AFIX_RDL_0: begin
                        bytes_to_skip = bytes_to_skip | {8'h00, b};
                        if (!ttl_any || ttl_build < ttl_low) begin
                            ttl_low = ttl_build;
                            ttl_any = 1'b1;
                        end
                        answers_todo = answers_todo - CNT_W'(1);
                        if (bytes_to_skip == 0) answer_over();
                        else stage = PH_RDATA;
                    end
                    default: ;
                endcase
                fix_pos = fix_pos + IDX_W'(1);
            end
            PH_RDATA: begin
                bytes_to_skip = bytes_to_skip - CNT_W'(1);
                if (bytes_to_skip == 0) answer_over();
            end
            default: ;  // done or failed: ignore until the final byte
        endcase
        if (it.last_byte) begin
            ok = (stage == PH_DONE) && ttl_any;
            min_ttl_due.push_back('{ttl_valid: ok, min_ttl: ok ? ttl_low : '0});
            parser_clear();
        end
    endtask

    // ------------------------------------------------------------------
    // Message construction
    // ------------------------------------------------------------------
    function automatic logic [7:0] rnd8();
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic put(input logic [7:0] b);
        msg_bytes.push_back(b);
    endtask

    task automatic put_header(input logic [15:0] qd, input logic [15:0] an);
        put(rnd8());
        put(rnd8());
        put(rnd8());
        put(rnd8());
        put(qd[15:8]);
        put(qd[7:0]);
        put(an[15:8]);
        put(an[7:0]);
        repeat (4) put(rnd8());
    endtask

    // Random labels, ended by a zero byte or a compression pointer. A bad
    // name opens with a reserved label type (01 or 10 in the top bits).
    task automatic put_name(input bit bad);
        int n;
        int len;
        n = $urandom_range(0, 3);
        if (bad) begin
            put({($urandom_range(0, 1) != 0) ? 2'b01 : 2'b10, 6'($urandom_range(0, 63))});
        end
        for (int i = 0; i < n; i++) begin
            len = ($urandom_range(0, 15) == 0) ? 63 : $urandom_range(1, 6);
            put(8'(len));
            repeat (len) put(rnd8());
        end
        if ($urandom_range(0, 2) == 0) begin
            put({LBL_PTR, 6'($urandom_range(0, 63))});
            put(rnd8());
        end else begin
            put(8'h00);
        end
    endtask

    task automatic put_question(input bit bad);
        put_name(bad);
        repeat (4) put(rnd8());
    endtask

    task automatic put_answer(input logic [31:0] ttl, input logic [15:0] rdlen, input bit bad);
        put_name(bad);
        repeat (4) put(rnd8());
        put(ttl[31:24]);
        put(ttl[23:16]);
        put(ttl[15:8]);
        put(ttl[7:0]);
        put(rdlen[15:8]);
        put(rdlen[7:0]);
        repeat (rdlen) put(rnd8());
    endtask

    // Queue the first keep bytes of the message, flagging the last one.
    task automatic send_msg(input int keep);
        t_in_item it;
        for (int i = 0; i < keep; i++) begin
            it.data_byte = msg_bytes[i];
            it.last_byte = (i == keep - 1);
            byte_backlog.push_back(it);
        end
        msgs_queued++;
        msg_bytes.delete();
    endtask

    function automatic logic [31:0] pick_ttl();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 600);
            2: return $urandom | 32'h8000_0000;
            default: return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
        endcase
    endfunction

    function automatic logic [15:0] pick_rdlen();
        case ($urandom_range(0, 19))
            0: return 16'($urandom_range(256, 300));
            1: return 16'd0;
            default: return 16'($urandom_range(1, 6));
        endcase
    endfunction

    // Mostly well-formed responses with random content; the rest are noise,
    // reserved labels, trailing junk and truncation.
    task automatic gen_random_msg();
        int kind;
        int qd;
        int an;
        int bad_at;
        int keep;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            repeat ($urandom_range(1, 30)) put(rnd8());
            send_msg(msg_bytes.size());
        end else begin
            qd = $urandom_range(0, 2);
            an = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 4);
            bad_at = (kind == 1 && qd + an > 0) ? $urandom_range(0, qd + an - 1) : -1;
            put_header(16'(qd), 16'(an));
            for (int i = 0; i < qd; i++) put_question(i == bad_at);
            for (int i = 0; i < an; i++) put_answer(pick_ttl(), pick_rdlen(), qd + i == bad_at);
            if (kind == 2) repeat ($urandom_range(1, 6)) put(rnd8());
            keep = msg_bytes.size();
            if (kind == 3 && keep > 1) keep = $urandom_range(1, keep - 1);
            send_msg(keep);
        end
    endtask

    task automatic gen_directed();
        // short: one byte, then eleven
        put(8'hFF);
        send_msg(1);
        repeat (11) put(8'hFF);
        send_msg(11);
        // header only, no answers
        put_header(16'd0, 16'd0);
        send_msg(12);
        // one answer, TTL with sign bit set and all ones
        put_header(16'd0, 16'd1);
        put_answer(32'hFFFF_FFFF, 16'd0, 1'b0);
        send_msg(msg_bytes.size());
        // question then two answers: top-bit TTL must lose its sign bit before compare
        put_header(16'd1, 16'd2);
        put_question(1'b0);
        put_answer(32'd5, 16'd4, 1'b0);
        put_answer(32'h8000_0001, 16'd2, 1'b0);
        send_msg(msg_bytes.size());
        // zero TTL and a name that is only a pointer
        put_header(16'd0, 16'd1);
        put(8'hC0);
        put(8'h0C);
        repeat (4) put(8'h00);
        repeat (4) put(8'h00);
        put(8'h00);
        put(8'h00);
        send_msg(msg_bytes.size());
        // reserved label in an answer name
        put_header(16'd0, 16'd1);
        put_answer(32'd100, 16'd1, 1'b1);
        send_msg(msg_bytes.size());
        // reserved label in a question name
        put_header(16'd1, 16'd1);
        put_question(1'b1);
        put_answer(32'd100, 16'd1, 1'b0);
        send_msg(msg_bytes.size());
        // truncated inside RDATA
        put_header(16'd0, 16'd1);
        put_answer(32'd77, 16'd6, 1'b0);
        send_msg(msg_bytes.size() - 3);
        // trailing bytes after a complete parse
        put_header(16'd0, 16'd1);
        put_answer(32'd1234, 16'd1, 1'b0);
        repeat (5) put(rnd8());
        send_msg(msg_bytes.size());
        // maximum question count: never reaches the answers
        put_header(16'hFFFF, 16'hFFFF);
        put_question(1'b0);
        put_answer(32'd9, 16'd0, 1'b0);
        send_msg(msg_bytes.size());
    endtask

    // ------------------------------------------------------------------
    // Driver: bursts of random length separated by random gaps. Advance
    // the predictor on each accepted byte; hold the item while stalled.
    // ------------------------------------------------------------------
    int burst_left;
    int gap_left;

    always @(posedge i_clk) begin
        t_in_item nxt_item;
        logic     nxt_valid;
        if (!i_rst_n) begin
            in_valid   <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
            parser_clear();
        end else begin
            nxt_valid = in_valid;
            nxt_item  = in_item;
            if (in_valid && o_s_axis_tready) begin
                parse_dns_byte(in_item);
                bytes_taken++;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (byte_backlog.size() > 0) begin
                    nxt_item  = byte_backlog.pop_front();
                    nxt_valid = 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        // pick the next burst; some long bursts with no gaps at all
                        burst_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 48);
                        case ($urandom_range(0, 3))
                            0, 1: gap_left = 0;
                            2: gap_left = $urandom_range(1, 4);
                            default: gap_left = $urandom_range(5, 20);
                        endcase
                    end
                end
            end
            in_valid <= nxt_valid;
            in_item  <= nxt_item;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each accepted result with the oldest prediction,
    // and stall the result side on a mode picked anew each time cyc[7:0] is zero.
    // ------------------------------------------------------------------
    logic [31:0] cyc = '0;
    logic [1:0]  rx_mode = '0;

    always @(posedge i_clk) begin
        t_result want;
        cyc <= cyc + 32'd1;
        if (cyc[7:0] == 8'h00) rx_mode <= 2'($urandom_range(0, 3));
        case (rx_mode)
            2'd0: rx_ready <= 1'b1;                   // never stall
            2'd1: rx_ready <= (cyc[1:0] == 2'b00);   // only when cyc[1:0] is zero
            2'd2: rx_ready <= ($urandom_range(0, 3) != 0);
            default: rx_ready <= (cyc[4:0] >= 5'd24); // long stalls
        endcase
        if (i_rst_n && o_m_axis_tvalid && rx_ready) begin
            if (min_ttl_due.size() == 0) begin
                $error("result with nothing expected: ttl_valid %0b, min_ttl 0x%08h",
                       o_m_axis_tuser, o_m_axis_tdata[TTL_W-1:0]);
                errors++;
            end else begin
                want = min_ttl_due.pop_front();
                results_seen++;
                if (want.ttl_valid) valid_seen++;
                if (o_m_axis_tuser !== want.ttl_valid) begin
                    $error("ttl_valid: expected %0b, actual %0b", want.ttl_valid, o_m_axis_tuser);
                    errors++;
                end
                if (o_m_axis_tdata[TTL_W-1:0] !== want.min_ttl) begin
                    $error("min_ttl: expected 0x%08h, actual 0x%08h",
                           want.min_ttl, o_m_axis_tdata[TTL_W-1:0]);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run when no handshake happens for too long.
    // ------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && o_s_axis_tready) || (o_m_axis_tvalid && rx_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("dns_answer_min_ttl_parser: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        int planned;
        errors       = 0;
        bytes_taken  = 0;
        msgs_queued  = 0;
        results_seen = 0;
        valid_seen   = 0;
        gen_directed();
        while (byte_backlog.size() < BYTE_TARGET) begin
            gen_random_msg();
        end
        planned = byte_backlog.size();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // drain: every byte accepted and every predicted result seen
        while (byte_backlog.size() != 0 || in_valid || min_ttl_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (8) @(posedge i_clk);
        $display("run covered %0d of %0d bytes in %0d messages", bytes_taken, planned,
                 msgs_queued);
        $display("results checked: %0d, of which %0d carried a valid TTL", results_seen,
                 valid_seen);
        if (errors == 0 && min_ttl_due.size() == 0) begin
            $display("dns_answer_min_ttl_parser: match");
        end else begin
            $display("dns_answer_min_ttl_parser: mismatch");
        end
        $finish;
    end

endmodule
`default_nettype wire

### files.f
design/dnsat_pkg.sv
design/dnsat_in_reg.sv
design/dnsat_parse.sv
design/dnsat_out_reg.sv
design/dns_answer_min_ttl_parser.sv
test/tb_dns_answer_min_ttl_parser.sv
